// ===== rtl/deq_pkg.sv =====
// shared types and defaults for the double-ended queue
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		KIND_PUSH_BACK  = 2'd0,
		KIND_POP_FRONT  = 2'd1,
		KIND_PUSH_FRONT = 2'd2,
		KIND_POP_BACK   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/double_ended_queue_top.sv =====
// top level of the double-ended queue
`default_nettype none

// Bounded double-ended queue of DEPTH signed 32-bit words in a ring buffer.
// Each beat on the input carries one operation (push back, pop front, push
// front, pop back) and yields exactly one result beat: the popped word (zero
// for pushes and refused pops), a status and the word count after the
// operation. A new operation is taken every cycle while the input is not
// stalled; its result appears in the cycle after acceptance, as the slot
// memory read data is registered. A result stalled at the output holds, and
// the input stalls with it because the slot memory read register holds the
// pending popped word. Slots that were never written have no defined contents.
module double_ended_queue_top import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               kind,
	input  wire logic signed [WORD_W-1:0] push_value,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [WORD_W-1:0]      pop_value,
	output logic [1:0]                    status,
	output logic [CNT_W-1:0]              occupancy
);

	logic                     wr_en, rd_en, pop_ok_s1;
	logic [IDX_W-1:0]         wr_addr, rd_addr;
	logic signed [WORD_W-1:0] wr_data, rd_data;
	status_t                  status_s1;

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind_t'(kind)),
		.push_value   (push_value),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.out_valid_s1 (out_valid),
		.out_stall    (out_stall),
		.pop_ok_s1    (pop_ok_s1),
		.status_s1    (status_s1),
		.occupancy_s1 (occupancy)
	);

	deq_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign pop_value = pop_ok_s1 ? rd_data : '0;
	assign status    = status_s1;

endmodule

`default_nettype wire

// ===== rtl/deq_mem.sv =====
// slot storage: one write port, one read port with registered read data
`default_nettype none

module deq_mem import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [IDX_W-1:0]         wr_addr,
	input  wire logic signed [WORD_W-1:0] wr_data,
	input  wire logic                     rd_en,
	input  wire logic [IDX_W-1:0]         rd_addr,
	output logic signed [WORD_W-1:0]      rd_data
);

	logic signed [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
// pointer and count bookkeeping, slot access requests and the result stage
`default_nettype none

module deq_ctrl import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire kind_t                    kind,
	input  wire logic signed [WORD_W-1:0] push_value,
	output logic                          wr_en,
	output logic [IDX_W-1:0]              wr_addr,
	output logic signed [WORD_W-1:0]      wr_data,
	output logic                          rd_en,
	output logic [IDX_W-1:0]              rd_addr,
	output logic                          out_valid_s1,
	input  wire logic                     out_stall,
	output logic                          pop_ok_s1,
	output status_t                       status_s1,
	output logic [CNT_W-1:0]              occupancy_s1
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [IDX_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [IDX_W-1:0] head_next, head_prev, tail_next, tail_prev;
	logic [CNT_W-1:0] count_q, count_d;
	logic             accept, empty, full, pop_ok;
	status_t          status_d;

	assign in_stall = out_valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;
	assign empty    = (count_q == '0);
	assign full     = (count_q == FULL_CNT);

	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

	assign wr_data = push_value;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		status_d = ST_DONE;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		rd_en    = 1'b0;
		rd_addr  = head_q;
		pop_ok   = 1'b0;
		unique case (kind)
			KIND_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = accept;
					wr_addr = tail_q;
					tail_d  = tail_next;
					count_d = count_q + 1'b1;
				end
			end
			KIND_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = accept;
					wr_addr = head_prev;
					head_d  = head_prev;
					count_d = count_q + 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en   = accept;
					rd_addr = head_q;
					head_d  = head_next;
					count_d = count_q - 1'b1;
					pop_ok  = 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en   = accept;
					rd_addr = tail_prev;
					tail_d  = tail_prev;
					count_d = count_q - 1'b1;
					pop_ok  = 1'b1;
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			out_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				head_q       <= head_d;
				tail_q       <= tail_d;
				count_q      <= count_d;
				out_valid_s1 <= 1'b1;
			end else if (!out_stall) begin
				out_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_ok_s1    <= pop_ok;
			status_s1    <= status_d;
			occupancy_s1 <= count_d;
		end
	end

endmodule

`default_nettype wire
